>>> rtl/bvws_pkg.sv
package bvws_pkg;

  // conversion constants of the base-2 formulation
  localparam logic [28:0] K1  = 29'd376736744;   // 0.0608*log2(e), Q32
  localparam logic [20:0] K2  = 21'd1378989;     // 14.585*log2(e), Q16
  localparam logic [24:0] K3  = 25'd21431887;    // 0.00499, Q32
  localparam logic [31:0] LN2 = 32'd2977044472;  // ln 2, Q32

  // hematocrit clamp bounds, Q1.15
  localparam logic [15:0] HCT_MIN = 16'd8192;
  localparam logic [15:0] HCT_ONE = 16'd32768;

  localparam logic [47:0] VISC_MAX = 48'hFFFF_FFFF_FFFF;

  // iteration counts
  localparam int LOG_STEPS = 28;
  localparam int EXP_TERMS = 12;
  localparam int QUOT_BITS = 64;

  // register reset values
  localparam logic [47:0] RST_COEF  = 48'd8763014345;
  localparam logic [23:0] RST_TPMA  = 24'd1638400;
  localparam logic [47:0] RST_FLOOR = 48'd0;
  localparam logic [47:0] RST_CEIL  = 48'hFFFF_FFFF_FFFF;
  localparam logic [19:0] RST_RHO1  = 20'd280576;
  localparam logic [19:0] RST_RHO2  = 20'd263936;

  typedef enum logic [2:0] {
    REG_COEF  = 3'd0,
    REG_TPMA  = 3'd1,
    REG_FLOOR = 3'd2,
    REG_CEIL  = 3'd3,
    REG_RHO1  = 3'd4,
    REG_RHO2  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] coef;
    logic [23:0] tpma;
    logic [47:0] vfloor;
    logic [47:0] vceil;
    logic [19:0] rho1;
    logic [19:0] rho2;
  } cfg_t;

  // front end to log/divide section
  typedef struct packed {
    logic [31:0] m;
    logic [4:0]  p;
    logic [62:0] num;
    logic [43:0] den;
    logic [35:0] t1;
    logic [29:0] ch;
    logic [35:0] rho;
  } front_t;

  // log/divide section to exponent section
  typedef struct packed {
    logic [35:0] t1;
    logic [35:0] t2;
    logic [29:0] ch;
    logic        neg;
    logic [32:0] mag;
    logic [35:0] rho;
  } ld_t;

  // exponent section to quotient section
  typedef struct packed {
    logic [32:0] pw;
    logic [6:0]  k;
    logic [35:0] rho;
  } ex_t;

  // index of the top set bit, zero for zero
  function automatic logic [5:0] lead_pos(input logic [47:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // ceil(2^35/n): exact floor division of 32-bit values by n via multiply
  function automatic logic [35:0] recip(input logic [3:0] n);
    logic [35:0] r;
    case (n)
      4'd2:    r = 36'd17179869184;
      4'd3:    r = 36'd11453246123;
      4'd4:    r = 36'd8589934592;
      4'd5:    r = 36'd6871947674;
      4'd6:    r = 36'd5726623062;
      4'd7:    r = 36'd4908534053;
      4'd8:    r = 36'd4294967296;
      4'd9:    r = 36'd3817748708;
      4'd10:   r = 36'd3435973837;
      4'd11:   r = 36'd3123612579;
      4'd12:   r = 36'd2863311531;
      default: r = 36'd34359738368;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/blood_viscosity_walburn_schneck_top.sv
// Walburn-Schneck blood viscosity pipeline. Each word (hematocrit, shear_rate)
// taken on start gives one kinematic_viscosity word on the done strobe, in
// order. One word can be taken every cycle: busy is always low, and results
// cannot be held off, so the receiver must take done whenever it rises. The
// pipeline is built from the 28-step log2 squaring chain (with the hematocrit
// divide in the same stages), the 12-term exp2 series at two stages a term,
// and the 64-bit quotient by mixture density at one bit a stage. Registers
// are written through cfg_wr_en/cfg_index/cfg_data and must only be changed
// while no word is in flight; indexes 6 and 7 are ignored.
module blood_viscosity_walburn_schneck_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] hematocrit,
  input  logic [31:0] shear_rate,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        done,
  output logic [47:0] kinematic_viscosity
);

  bvws_pkg::cfg_t   cfg;
  bvws_pkg::front_t fr_data;
  bvws_pkg::ld_t    ld_data;
  bvws_pkg::ex_t    ex_data;
  logic             fr_vld, ld_vld, ex_vld;
  logic [31:0]      cm;
  logic [5:0]       pc;
  logic             coef_zero;
  logic [5:0]       cpos;
  logic [47:0]      cnorm;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef   <= bvws_pkg::RST_COEF;
      cfg.tpma   <= bvws_pkg::RST_TPMA;
      cfg.vfloor <= bvws_pkg::RST_FLOOR;
      cfg.vceil  <= bvws_pkg::RST_CEIL;
      cfg.rho1   <= bvws_pkg::RST_RHO1;
      cfg.rho2   <= bvws_pkg::RST_RHO2;
    end else if (cfg_wr_en) begin
      unique case (bvws_pkg::reg_idx_t'(cfg_index))
        bvws_pkg::REG_COEF:  cfg.coef   <= cfg_data;
        bvws_pkg::REG_TPMA:  cfg.tpma   <= cfg_data[23:0];
        bvws_pkg::REG_FLOOR: cfg.vfloor <= cfg_data;
        bvws_pkg::REG_CEIL:  cfg.vceil  <= cfg_data;
        bvws_pkg::REG_RHO1:  cfg.rho1   <= cfg_data[19:0];
        bvws_pkg::REG_RHO2:  cfg.rho2   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // coefficient split into 32-bit mantissa and exponent
  always_comb begin
    cpos  = bvws_pkg::lead_pos(cfg.coef);
    cnorm = (cpos >= 6'd31) ? (cfg.coef >> (cpos - 6'd31)) : (cfg.coef << (6'd31 - cpos));
  end

  always_ff @(posedge clk) begin
    cm        <= cnorm[31:0];
    pc        <= cpos;
    coef_zero <= (cfg.coef == 48'd0);
  end

  bvws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (start),
    .hematocrit (hematocrit),
    .shear_rate (shear_rate),
    .cfg        (cfg),
    .out_vld    (fr_vld),
    .out_data   (fr_data)
  );

  bvws_logdiv u_logdiv (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (fr_vld),
    .in_data  (fr_data),
    .out_vld  (ld_vld),
    .out_data (ld_data)
  );

  bvws_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (ld_vld),
    .in_data  (ld_data),
    .out_vld  (ex_vld),
    .out_data (ex_data)
  );

  bvws_quot u_quot (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (ex_vld),
    .in_data   (ex_data),
    .cfg       (cfg),
    .cm        (cm),
    .pc        (pc),
    .coef_zero (coef_zero),
    .out_vld   (done),
    .out_visc  (kinematic_viscosity)
  );

endmodule

>>> rtl/bvws_front.sv
module bvws_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [15:0]         hematocrit,
  input  logic [31:0]         shear_rate,
  input  bvws_pkg::cfg_t      cfg,
  output logic                out_vld,
  output bvws_pkg::front_t    out_data
);

  logic [15:0] fc_clamp;
  logic [31:0] g_floor;
  logic        v1, v2;
  logic [15:0] fc1;
  logic [31:0] g1;
  logic [21:0] hq2;
  logic [4:0]  p2;
  logic [31:0] m2;
  logic [35:0] prod1, prod2;
  logic [5:0]  pos;
  logic [50:0] mult1;
  logic [46:0] mult3;
  logic [44:0] mult2;
  logic [43:0] hsq;

  // input clamp and strain floor
  always_comb begin
    fc_clamp = hematocrit;
    if (hematocrit < bvws_pkg::HCT_MIN) fc_clamp = bvws_pkg::HCT_MIN;
    if (hematocrit > bvws_pkg::HCT_ONE) fc_clamp = bvws_pkg::HCT_ONE;
    g_floor = (shear_rate == 32'd0) ? 32'd1 : shear_rate;
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_vld;
    fc1 <= fc_clamp;
    g1  <= g_floor;
  end

  // stage 2: scale, normalize strain rate, density products
  always_comb begin
    pos = bvws_pkg::lead_pos({16'b0, g1});
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    hq2   <= 22'(fc1 * 7'd100);
    p2    <= pos[4:0];
    m2    <= g1 << (5'd31 - pos[4:0]);
    prod1 <= cfg.rho1 * fc1;
    prod2 <= cfg.rho2 * (bvws_pkg::HCT_ONE - fc1);
  end

  // stage 3: exponent terms and divider operands
  always_comb begin
    mult1 = bvws_pkg::K1 * hq2;
    mult3 = bvws_pkg::K3 * hq2;
    mult2 = bvws_pkg::K2 * cfg.tpma;
    hsq   = hq2 * hq2;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= v2;
    out_data.m   <= m2;
    out_data.p   <= p2;
    out_data.num <= {mult2, 18'b0};
    out_data.den <= hsq;
    out_data.t1  <= mult1[50:15];
    out_data.ch  <= mult3[46:17];
    out_data.rho <= 36'(prod1 + prod2);
  end

endmodule

>>> rtl/bvws_logdiv.sv
module bvws_logdiv (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  bvws_pkg::front_t   in_data,
  output logic               out_vld,
  output bvws_pkg::ld_t      out_data
);

  typedef struct packed {
    logic [31:0]                    m;
    logic [bvws_pkg::LOG_STEPS-1:0] fr;
    logic [43:0]                    rem;
    logic [bvws_pkg::LOG_STEPS-1:0] nlo;
    logic [bvws_pkg::LOG_STEPS-1:0] q;
    logic [4:0]                     p;
    logic [43:0]                    den;
    logic [35:0]                    t1;
    logic [29:0]                    ch;
    logic [35:0]                    rho;
  } stage_t;

  stage_t s0;
  stage_t st  [1:bvws_pkg::LOG_STEPS];
  logic   vld [1:bvws_pkg::LOG_STEPS];

  // entry: mantissa in Q1.31, divider remainder seeded with the high numerator bits
  always_comb begin
    s0.m   = in_data.m;
    s0.fr  = '0;
    s0.rem = 44'(in_data.num[62:bvws_pkg::LOG_STEPS]);
    s0.nlo = in_data.num[bvws_pkg::LOG_STEPS-1:0];
    s0.q   = '0;
    s0.p   = in_data.p;
    s0.den = in_data.den;
    s0.t1  = in_data.t1;
    s0.ch  = in_data.ch;
    s0.rho = in_data.rho;
  end

  // one squaring step of the log and one quotient bit per stage
  for (genvar i = 0; i < bvws_pkg::LOG_STEPS; i++) begin : g_step
    stage_t      cur;
    logic        cur_vld;
    logic [63:0] sq;
    logic [32:0] ms;
    logic [44:0] trial;
    logic        lb, qb;
    logic [31:0] m_n;
    logic [43:0] rem_n;

    if (i == 0) begin : g_first
      assign cur     = s0;
      assign cur_vld = in_vld;
    end else begin : g_next
      assign cur     = st[i];
      assign cur_vld = vld[i];
    end

    always_comb begin
      sq    = cur.m * cur.m;
      ms    = sq[63:31];
      lb    = ms[32];
      m_n   = lb ? ms[32:1] : ms[31:0];
      trial = {cur.rem, cur.nlo[bvws_pkg::LOG_STEPS-1]};
      qb    = (trial >= {1'b0, cur.den});
      rem_n = qb ? 44'(trial - {1'b0, cur.den}) : trial[43:0];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= cur_vld;
      st[i+1].m   <= m_n;
      st[i+1].fr  <= {cur.fr[bvws_pkg::LOG_STEPS-2:0], lb};
      st[i+1].rem <= rem_n;
      st[i+1].nlo <= {cur.nlo[bvws_pkg::LOG_STEPS-2:0], 1'b0};
      st[i+1].q   <= {cur.q[bvws_pkg::LOG_STEPS-2:0], qb};
      st[i+1].p   <= cur.p;
      st[i+1].den <= cur.den;
      st[i+1].t1  <= cur.t1;
      st[i+1].ch  <= cur.ch;
      st[i+1].rho <= cur.rho;
    end
  end

  // log2(rate) - 16 as sign and magnitude, quotient scaled to Q32
  logic [5:0]  ip;
  logic [33:0] lg, lg_neg;

  always_comb begin
    ip     = 6'({1'b0, st[bvws_pkg::LOG_STEPS].p}) - 6'd16;
    lg     = {ip, st[bvws_pkg::LOG_STEPS].fr};
    lg_neg = 34'd0 - lg;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= vld[bvws_pkg::LOG_STEPS];
    out_data.t1  <= st[bvws_pkg::LOG_STEPS].t1;
    out_data.t2  <= {st[bvws_pkg::LOG_STEPS].q[23:0], 12'b0};
    out_data.ch  <= st[bvws_pkg::LOG_STEPS].ch;
    out_data.neg <= ip[5];
    out_data.mag <= ip[5] ? lg_neg[32:0] : lg[32:0];
    out_data.rho <= st[bvws_pkg::LOG_STEPS].rho;
  end

endmodule

>>> rtl/bvws_exp.sv
module bvws_exp (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  bvws_pkg::ld_t    in_data,
  output logic             out_vld,
  output bvws_pkg::ex_t    out_data
);

  localparam int NST = 2 * bvws_pkg::EXP_TERMS;

  typedef struct packed {
    logic [32:0] sum;
    logic [31:0] term;
    logic [31:0] x;
    logic [30:0] y;
    logic [6:0]  k;
    logic [35:0] rho;
  } stage_t;

  logic        v1, v2, v3;
  logic [36:0] t12, t3;
  logic        neg1;
  logic [35:0] rho1, rho2;
  logic [62:0] tp;
  logic [38:0] e;
  logic [6:0]  k2;
  logic [31:0] fr2;
  logic [63:0] yp;
  stage_t      s0;
  stage_t      st  [1:NST];
  logic        vld [1:NST];

  // total exponent: strain term product
  always_comb begin
    tp = in_data.ch * in_data.mag;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_vld;
    t12  <= {1'b0, in_data.t1} + {1'b0, in_data.t2};
    t3   <= tp[62:26];
    neg1 <= in_data.neg;
    rho1 <= in_data.rho;
  end

  // signed sum, split into integer and fraction
  always_comb begin
    e = neg1 ? ({2'b0, t12} + {2'b0, t3}) : ({2'b0, t12} - {2'b0, t3});
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    k2   <= e[38:32];
    fr2  <= e[31:0];
    rho2 <= rho1;
  end

  // taylor argument y = fr*ln2
  always_comb begin
    yp = fr2 * bvws_pkg::LN2;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    s0.sum  <= '0;
    s0.term <= 32'h8000_0000;
    s0.x    <= '0;
    s0.y    <= yp[63:33];
    s0.k    <= k2;
    s0.rho  <= rho2;
  end

  // each term takes two stages: multiply by y, then divide by n
  for (genvar j = 1; j <= NST; j++) begin : g_term
    localparam logic [3:0] N = 4'((j + 1) / 2);
    stage_t cur;
    logic   cur_vld;

    if (j == 1) begin : g_first
      assign cur     = s0;
      assign cur_vld = v3;
    end else begin : g_next
      assign cur     = st[j-1];
      assign cur_vld = vld[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[j] <= 1'b0;
      else vld[j] <= cur_vld;
    end

    if (j % 2 == 1) begin : g_mul
      logic [62:0] xp;
      always_comb begin
        xp = cur.term * cur.y;
      end
      always_ff @(posedge clk) begin
        st[j].sum  <= 33'(cur.sum + {1'b0, cur.term});
        st[j].term <= cur.term;
        st[j].x    <= xp[62:31];
        st[j].y    <= cur.y;
        st[j].k    <= cur.k;
        st[j].rho  <= cur.rho;
      end
    end else begin : g_div
      logic [67:0] dp;
      always_comb begin
        dp = cur.x * bvws_pkg::recip(N);
      end
      always_ff @(posedge clk) begin
        st[j].sum  <= cur.sum;
        st[j].term <= dp[66:35];
        st[j].x    <= cur.x;
        st[j].y    <= cur.y;
        st[j].k    <= cur.k;
        st[j].rho  <= cur.rho;
      end
    end
  end

  // last term added
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= vld[NST];
    out_data.pw  <= 33'(st[NST].sum + {1'b0, st[NST].term});
    out_data.k   <= st[NST].k;
    out_data.rho <= st[NST].rho;
  end

endmodule

>>> rtl/bvws_quot.sv
module bvws_quot (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  bvws_pkg::ex_t    in_data,
  input  bvws_pkg::cfg_t   cfg,
  input  logic [31:0]      cm,
  input  logic [5:0]       pc,
  input  logic             coef_zero,
  output logic             out_vld,
  output logic [47:0]      out_visc
);

  localparam int NQ = bvws_pkg::QUOT_BITS;

  typedef struct packed {
    logic [35:0]   rem;
    logic [NQ-1:0] nq;
    logic [35:0]   rho;
    logic [7:0]    s;
    logic          rz;
    logic          cz;
  } stage_t;

  logic        v1, v2;
  stage_t      s0;
  stage_t      st  [1:NQ];
  logic        vld [1:NQ];
  logic [64:0] prod;

  // mantissa product and result exponent
  always_comb begin
    prod = cm * in_data.pw;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_vld;
    s0.rem <= '0;
    s0.nq  <= prod[NQ-1:0];
    s0.rho <= in_data.rho;
    s0.s   <= {2'b0, pc} + {in_data.k[6], in_data.k} - 8'd39;
    s0.rz  <= (in_data.rho == 36'd0);
    s0.cz  <= coef_zero;
  end

  // restoring division by mixture density, one quotient bit per stage
  for (genvar i = 1; i <= NQ; i++) begin : g_div
    stage_t      cur;
    logic        cur_vld;
    logic [36:0] trial;
    logic        qb;

    if (i == 1) begin : g_first
      assign cur     = s0;
      assign cur_vld = v1;
    end else begin : g_next
      assign cur     = st[i-1];
      assign cur_vld = vld[i-1];
    end

    always_comb begin
      trial = {cur.rem, cur.nq[NQ-1]};
      qb    = (trial >= {1'b0, cur.rho});
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else vld[i] <= cur_vld;
      st[i].rem <= qb ? 36'(trial - {1'b0, cur.rho}) : trial[35:0];
      st[i].nq  <= {cur.nq[NQ-2:0], qb};
      st[i].rho <= cur.rho;
      st[i].s   <= cur.s;
      st[i].rz  <= cur.rz;
      st[i].cz  <= cur.cz;
    end
  end

  // scale by 2^s with saturation
  logic [NQ-1:0] r, lim, rs;
  logic [7:0]    sh;
  logic [47:0]   nu;
  logic [47:0]   nu_r, capped;

  always_comb begin
    r   = st[NQ].nq;
    sh  = 8'd0 - st[NQ].s;
    lim = {16'b0, bvws_pkg::VISC_MAX} >> st[NQ].s[5:0];
    rs  = r >> sh[5:0];
    nu  = '0;
    if (st[NQ].cz) begin
      nu = '0;
    end else if (st[NQ].rz) begin
      nu = bvws_pkg::VISC_MAX;
    end else if (!st[NQ].s[7]) begin
      if (st[NQ].s[6:0] >= 7'd48 || r > lim) nu = bvws_pkg::VISC_MAX;
      else nu = 48'(r << st[NQ].s[5:0]);
    end else begin
      if (rs > {16'b0, bvws_pkg::VISC_MAX}) nu = bvws_pkg::VISC_MAX;
      else nu = rs[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= vld[NQ];
    nu_r <= nu;
  end

  // ceiling first, floor last
  always_comb begin
    capped = (nu_r > cfg.vceil) ? cfg.vceil : nu_r;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= v2;
    out_visc <= (capped < cfg.vfloor) ? cfg.vfloor : capped;
  end

endmodule

>>> sim/tb_blood_viscosity_walburn_schneck_top.sv
module tb_blood_viscosity_walburn_schneck_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 127;

  typedef struct packed {
    logic [15:0] hct;
    logic [31:0] rate;
  } word_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] hematocrit;
  logic [31:0] shear_rate;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        done;
  logic [47:0] kinematic_viscosity;

  blood_viscosity_walburn_schneck_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .hematocrit(hematocrit), .shear_rate(shear_rate),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .kinematic_viscosity(kinematic_viscosity)
  );

  // register shadow
  logic [47:0] coef_q;
  logic [23:0] tpma_q;
  logic [47:0] floor_q;
  logic [47:0] ceil_q;
  logic [19:0] rho1_q;
  logic [19:0] rho2_q;

  word_t       pending_words[$];
  logic [47:0] expected_visc[$];
  int          mismatches;
  bit          feeding_paused;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic int top_set(input logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  // log2(rate) - 16, Q28, by squaring the mantissa
  function automatic longint log2_rate(input logic [63:0] g);
    int          p;
    logic [63:0] m;
    logic [63:0] f;
    p = top_set(g);
    m = g << (31 - p);
    f = 0;
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        f[0] = 1'b1;
      end
    end
    return longint'(p) * 268435456 - 64'sd16 * 268435456 + longint'(f);
  endfunction

  // 2^fraction, Q31, truncated Taylor series
  function automatic logic [63:0] pow2_frac(input logic [63:0] fr);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    y = (fr * 64'd2977044472) >> 33;
    sum = 64'h8000_0000;
    term = 64'h8000_0000;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * y) >> 31) / n;
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [47:0] predict_viscosity(input word_t w);
    logic [63:0] fc, hq, t1, t2, ch, g, mag, t3, u, fr, pw, rho, nu, cm, r;
    longint      lg, e;
    int          k, pc, s;
    fc = w.hct;
    if (fc < 8192) fc = 8192;
    if (fc > 32768) fc = 32768;
    hq = 100 * fc;
    t1 = (64'd376736744 * hq) >> 15;
    t2 = (((64'd1378989 * tpma_q) << 18) / (hq * hq)) << 12;
    ch = ((64'd21431887 * hq) >> 15) >> 2;
    g = w.rate;
    if (g == 0) g = 1;
    lg = log2_rate(g);
    mag = (lg < 0) ? 64'(-lg) : 64'(lg);
    t3 = (ch * mag) >> 26;
    e = longint'(t1) + longint'(t2);
    if (lg < 0) e = e + longint'(t3);
    else e = e - longint'(t3);
    u = 64'(e + 64'sd64 * 64'sh1_0000_0000);
    k = int'(u >> 32) - 64;
    fr = u & 64'hFFFF_FFFF;
    pw = pow2_frac(fr);
    rho = rho1_q * fc + rho2_q * (32768 - fc);
    if (coef_q == 0) begin
      nu = 0;
    end else if (rho == 0) begin
      nu = bvws_pkg::VISC_MAX;
    end else begin
      pc = top_set(coef_q);
      cm = (pc >= 31) ? (64'(coef_q) >> (pc - 31)) : (64'(coef_q) << (31 - pc));
      r = (cm * pw) / rho;
      s = pc + k - 39;
      if (s >= 0) begin
        if (s >= 48 || r > (64'(bvws_pkg::VISC_MAX) >> s)) nu = bvws_pkg::VISC_MAX;
        else nu = r << s;
      end else begin
        nu = (-s >= 64) ? 64'd0 : (r >> (-s));
        if (nu > bvws_pkg::VISC_MAX) nu = bvws_pkg::VISC_MAX;
      end
    end
    if (nu > ceil_q) nu = ceil_q;
    if (nu < floor_q) nu = floor_q;
    return nu[47:0];
  endfunction

  // word driver: pops one pending word per cycle unless paused
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_visc.push_back(predict_viscosity({hematocrit, shear_rate}));
      if ((!start || !busy) && !feeding_paused && pending_words.size() > 0) begin
        word_t w;
        w = pending_words.pop_front();
        start <= 1'b1;
        hematocrit <= w.hct;
        shear_rate <= w.rate;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_visc.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", kinematic_viscosity);
      end else begin
        logic [47:0] exp_v;
        exp_v = expected_visc.pop_front();
        if (exp_v !== kinematic_viscosity) begin
          mismatches++;
          if (mismatches <= 10)
            $display("viscosity mismatch: expected %h got %h", exp_v, kinematic_viscosity);
        end
      end
    end
  end

  task automatic write_reg(input bvws_pkg::reg_idx_t idx, input logic [47:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      bvws_pkg::REG_COEF:  coef_q = val;
      bvws_pkg::REG_TPMA:  tpma_q = val[23:0];
      bvws_pkg::REG_FLOOR: floor_q = val;
      bvws_pkg::REG_CEIL:  ceil_q = val;
      bvws_pkg::REG_RHO1:  rho1_q = val[19:0];
      bvws_pkg::REG_RHO2:  rho2_q = val[19:0];
      default: ;
    endcase
  endtask

  task automatic write_ignored_index();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= 3'(6 + $urandom_range(0, 1));
    cfg_data <= 48'({$urandom, $urandom});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    while (pending_words.size() > 0 || start || expected_visc.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w.hct = 16'($urandom);
      1: w.hct = 16'($urandom_range(0, 8192));
      default: w.hct = 16'($urandom_range(8192, 32768));
    endcase
    case ($urandom_range(0, 5))
      0: w.rate = $urandom;
      1: w.rate = 32'($urandom_range(0, 255));
      2: w.rate = 32'h1 << $urandom_range(0, 31);
      default: w.rate = 32'($urandom_range(1, 32'h0100_0000));
    endcase
    return w;
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pending_words.push_back(rand_word());
  endtask

  // bursts of traffic with random gaps
  initial begin
    feeding_paused = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        feeding_paused <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        feeding_paused <= 1'b0;
      end
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    int hcts[6];
    int rates[6];
    rst = 1'b1;
    start = 1'b0;
    hematocrit = '0;
    shear_rate = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    coef_q = bvws_pkg::RST_COEF;
    tpma_q = bvws_pkg::RST_TPMA;
    floor_q = bvws_pkg::RST_FLOOR;
    ceil_q = bvws_pkg::RST_CEIL;
    rho1_q = bvws_pkg::RST_RHO1;
    rho2_q = bvws_pkg::RST_RHO2;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners at reset settings
    hcts = '{0, 8191, 8192, 20000, 32768, 65535};
    rates = '{0, 1, 65536, 32'hFFFF_FFFF, 32'h8000_0000, 3};
    for (int i = 0; i < 6; i++) begin
      pending_words.push_back({16'(hcts[i]), 32'(rates[i])});
      pending_words.push_back({16'(hcts[5 - i]), 32'(rates[i])});
    end
    pending_words.push_back({16'hAAAA, 32'h5555_5555});
    pending_words.push_back({16'h5555, 32'hAAAA_AAAA});
    drain();

    // zero coefficient, then floor above ceiling, then zero density
    write_reg(bvws_pkg::REG_COEF, 48'd0);
    write_reg(bvws_pkg::REG_FLOOR, 48'd12345);
    pending_words.push_back({16'd16384, 32'd65536});
    drain();
    write_reg(bvws_pkg::REG_COEF, 48'hFFFF_FFFF_FFFF);
    write_reg(bvws_pkg::REG_CEIL, 48'd100);
    write_reg(bvws_pkg::REG_TPMA, 48'hFF_FFFF);
    pending_words.push_back({16'd8192, 32'd0});
    pending_words.push_back({16'd32768, 32'hFFFF_FFFF});
    drain();
    write_reg(bvws_pkg::REG_FLOOR, 48'd0);
    write_reg(bvws_pkg::REG_CEIL, 48'hFFFF_FFFF_FFFF);
    write_reg(bvws_pkg::REG_RHO1, 48'd0);
    write_reg(bvws_pkg::REG_RHO2, 48'd0);
    write_ignored_index();
    pending_words.push_back({16'd16384, 32'd65536});
    pending_words.push_back({16'd8192, 32'd1});
    pending_words.push_back({16'd32768, 32'd1});
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(bvws_pkg::REG_COEF, bvws_pkg::RST_COEF);
          write_reg(bvws_pkg::REG_TPMA, 48'(bvws_pkg::RST_TPMA));
          write_reg(bvws_pkg::REG_RHO1, 48'(bvws_pkg::RST_RHO1));
          write_reg(bvws_pkg::REG_RHO2, 48'(bvws_pkg::RST_RHO2));
        end
        1: begin
          write_reg(bvws_pkg::REG_RHO1, 48'hF_FFFF);
          write_reg(bvws_pkg::REG_RHO2, 48'd1);
          write_reg(bvws_pkg::REG_COEF, 48'd1);
        end
        2: begin
          write_reg(bvws_pkg::REG_RHO1, 48'd1);
          write_reg(bvws_pkg::REG_RHO2, 48'hF_FFFF);
          write_reg(bvws_pkg::REG_TPMA, 48'd0);
          write_reg(bvws_pkg::REG_COEF, 48'hFFFF_FFFF_FFFF);
        end
        default: begin
          write_reg(bvws_pkg::REG_COEF, 48'({$urandom, $urandom} >> $urandom_range(0, 47)));
          write_reg(bvws_pkg::REG_TPMA, 48'(24'($urandom)));
          write_reg(bvws_pkg::REG_RHO1, 48'(20'($urandom_range(1, 20'hF_FFFF))));
          write_reg(bvws_pkg::REG_RHO2, 48'(20'($urandom_range(1, 20'hF_FFFF))));
          write_reg(bvws_pkg::REG_FLOOR, $urandom_range(0, 1) ? 48'd0 : 48'($urandom));
          write_reg(bvws_pkg::REG_CEIL, $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF
                                                             : {16'($urandom), $urandom});
        end
      endcase
      queue_random(160);
      drain();
    end

    if (mismatches == 0 && expected_visc.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bvws_pkg.sv
rtl/bvws_front.sv
rtl/bvws_logdiv.sv
rtl/bvws_exp.sv
rtl/bvws_quot.sv
rtl/blood_viscosity_walburn_schneck_top.sv
sim/tb_blood_viscosity_walburn_schneck_top.sv
